// File: rtl/core/spi_epsw_pkg.sv
package spi_epsw_pkg;

    // Page size; must be a power of two for the boundary check.
    localparam int PAGE_BYTES = 128;
    localparam int PAGE_BITS  = $clog2(PAGE_BYTES);

    localparam int MAX_RUN   = 6;
    localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0] DUMMY_BYTE = 8'hff;

    localparam logic [7:0] RST_READ_STATUS_OP  = 8'd5;
    localparam logic [7:0] RST_WRITE_ENABLE_OP = 8'd6;
    localparam logic [7:0] RST_PAGE_PROGRAM_OP = 8'd2;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_PAYLOAD = 2'd1,
        OP_STATUS  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_REJECT  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_POLL    = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        REG_READ_STATUS  = 2'd0,
        REG_WRITE_ENABLE = 2'd1,
        REG_PAGE_PROGRAM = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] start_address;
        logic [15:0] span_length;
        logic [7:0]  byte_in;
    } in_word_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] tx_byte;
        logic       wants_reply;
        logic       ready_for_payload;
        logic       last_of_run;
    } out_word_t;

    typedef struct packed {
        out_word_t [MAX_RUN-1:0]  words;
        logic [RUN_CNT_W-1:0]     count;
    } run_t;

    typedef struct packed {
        logic [7:0] read_status_op;
        logic [7:0] write_enable_op;
        logic [7:0] page_program_op;
    } cfg_t;

    function automatic out_word_t frame(kind_t k, logic [7:0] tx, logic reply);
        out_word_t w;
        w.kind              = k;
        w.tx_byte           = tx;
        w.wants_reply       = reply;
        w.ready_for_payload = 1'b0;
        w.last_of_run       = 1'b0;
        return w;
    endfunction

endpackage

// File: rtl/core/spi_epsw_cfg.sv
module spi_epsw_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [spi_epsw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [spi_epsw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [spi_epsw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output spi_epsw_pkg::cfg_t                   cfg
);

    spi_epsw_pkg::cfg_t cfg_reg;
    spi_epsw_pkg::cfg_t cfg_next;
    logic               wr_en;
    logic [1:0]         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                spi_epsw_pkg::REG_READ_STATUS:  cfg_next.read_status_op  = pwdata[7:0];
                spi_epsw_pkg::REG_WRITE_ENABLE: cfg_next.write_enable_op = pwdata[7:0];
                spi_epsw_pkg::REG_PAGE_PROGRAM: cfg_next.page_program_op = pwdata[7:0];
                default:                        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            spi_epsw_pkg::REG_READ_STATUS:  prdata = {24'd0, cfg_reg.read_status_op};
            spi_epsw_pkg::REG_WRITE_ENABLE: prdata = {24'd0, cfg_reg.write_enable_op};
            spi_epsw_pkg::REG_PAGE_PROGRAM: prdata = {24'd0, cfg_reg.page_program_op};
            default:                        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_status_op  <= spi_epsw_pkg::RST_READ_STATUS_OP;
            cfg_reg.write_enable_op <= spi_epsw_pkg::RST_WRITE_ENABLE_OP;
            cfg_reg.page_program_op <= spi_epsw_pkg::RST_PAGE_PROGRAM_OP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/spi_epsw_seq.sv
module spi_epsw_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  spi_epsw_pkg::in_word_t item,
    input  spi_epsw_pkg::cfg_t     cfg,
    output spi_epsw_pkg::run_t     run
);

    spi_epsw_pkg::phase_t phase_reg;
    spi_epsw_pkg::phase_t phase_next;
    logic [15:0]          address_reg;
    logic [15:0]          address_next;
    logic [15:0]          left_reg;
    logic [15:0]          left_next;

    logic        do_start;
    logic        do_status;
    logic        do_payload;
    logic [15:0] addr_inc;
    logic [15:0] left_dec;
    logic        page_end;
    logic        span_empty;
    logic        busy;

    assign do_start   = (item.operation == spi_epsw_pkg::OP_START)
                        && (phase_reg == spi_epsw_pkg::PH_IDLE);
    assign do_status  = (item.operation == spi_epsw_pkg::OP_STATUS)
                        && (phase_reg == spi_epsw_pkg::PH_POLL);
    assign do_payload = (item.operation == spi_epsw_pkg::OP_PAYLOAD)
                        && (phase_reg == spi_epsw_pkg::PH_PAYLOAD);
    assign addr_inc   = address_reg + 16'd1;
    assign left_dec   = left_reg - 16'd1;
    // wrap to zero also lands here
    assign page_end   = (addr_inc[spi_epsw_pkg::PAGE_BITS-1:0] == '0);
    assign span_empty = (item.span_length == 16'd0);
    assign busy       = item.byte_in[0];

    // next state
    always_comb
    begin
        phase_next   = phase_reg;
        address_next = address_reg;
        left_next    = left_reg;
        if (load)
        begin
            if (do_start)
            begin
                if (!span_empty)
                begin
                    phase_next   = spi_epsw_pkg::PH_POLL;
                    address_next = item.start_address;
                    left_next    = item.span_length;
                end
            end
            else if (do_status)
            begin
                if (!busy)
                    phase_next = spi_epsw_pkg::PH_PAYLOAD;
            end
            else if (do_payload)
            begin
                address_next = addr_inc;
                left_next    = left_dec;
                if (left_dec == 16'd0)
                    phase_next = spi_epsw_pkg::PH_IDLE;
                else if (page_end)
                    phase_next = spi_epsw_pkg::PH_POLL;
            end
        end
    end

    // result run for the item at the head
    always_comb
    begin
        run = '0;
        if (do_start)
        begin
            if (span_empty)
            begin
                run.words[0] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_DONE, 8'd0, 1'b0);
                run.words[0].last_of_run = 1'b1;
                run.count = (spi_epsw_pkg::RUN_CNT_W)'(1);
            end
            else
            begin
                run.words[0] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_TX,
                                                   cfg.read_status_op, 1'b0);
                run.words[1] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_TX,
                                                   spi_epsw_pkg::DUMMY_BYTE, 1'b1);
                run.words[1].last_of_run = 1'b1;
                run.count = (spi_epsw_pkg::RUN_CNT_W)'(2);
            end
        end
        else if (do_status)
        begin
            if (busy)
            begin
                run.words[0] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_TX,
                                                   spi_epsw_pkg::DUMMY_BYTE, 1'b1);
                run.words[0].last_of_run = 1'b1;
                run.count = (spi_epsw_pkg::RUN_CNT_W)'(1);
            end
            else
            begin
                run.words[0] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_RELEASE, 8'd0, 1'b0);
                run.words[1] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_TX,
                                                   cfg.write_enable_op, 1'b0);
                run.words[2] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_RELEASE, 8'd0, 1'b0);
                run.words[3] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_TX,
                                                   cfg.page_program_op, 1'b0);
                run.words[4] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_TX,
                                                   address_reg[15:8], 1'b0);
                run.words[5] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_TX,
                                                   address_reg[7:0], 1'b0);
                run.words[5].ready_for_payload = 1'b1;
                run.words[5].last_of_run       = 1'b1;
                run.count = (spi_epsw_pkg::RUN_CNT_W)'(6);
            end
        end
        else if (do_payload)
        begin
            run.words[0] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_TX, item.byte_in, 1'b0);
            if ((left_dec != 16'd0) && !page_end)
            begin
                run.words[0].ready_for_payload = 1'b1;
                run.words[0].last_of_run       = 1'b1;
                run.count = (spi_epsw_pkg::RUN_CNT_W)'(1);
            end
            else if (left_dec == 16'd0)
            begin
                run.words[1] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_RELEASE, 8'd0, 1'b0);
                run.words[2] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_DONE, 8'd0, 1'b0);
                run.words[2].last_of_run = 1'b1;
                run.count = (spi_epsw_pkg::RUN_CNT_W)'(3);
            end
            else
            begin
                // page boundary: close chunk, open next with a status poll
                run.words[1] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_RELEASE, 8'd0, 1'b0);
                run.words[2] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_TX,
                                                   cfg.read_status_op, 1'b0);
                run.words[3] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_TX,
                                                   spi_epsw_pkg::DUMMY_BYTE, 1'b1);
                run.words[3].last_of_run = 1'b1;
                run.count = (spi_epsw_pkg::RUN_CNT_W)'(4);
            end
        end
        else
        begin
            run.words[0] = spi_epsw_pkg::frame(spi_epsw_pkg::KIND_REJECT, 8'd0, 1'b0);
            run.words[0].last_of_run = 1'b1;
            run.count = (spi_epsw_pkg::RUN_CNT_W)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= spi_epsw_pkg::PH_IDLE;
            address_reg <= '0;
            left_reg    <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            address_reg <= address_next;
            left_reg    <= left_next;
        end
    end

endmodule

// File: rtl/core/spi_epsw_run_buf.sv
module spi_epsw_run_buf (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  spi_epsw_pkg::run_t      run,
    input  logic                    result_stall,
    output logic                    result_valid,
    output spi_epsw_pkg::out_word_t result,
    output logic                    can_load
);

    spi_epsw_pkg::out_word_t [spi_epsw_pkg::MAX_RUN-1:0] words_reg;
    spi_epsw_pkg::out_word_t [spi_epsw_pkg::MAX_RUN-1:0] words_next;
    logic [spi_epsw_pkg::RUN_CNT_W-1:0]                  count_reg;
    logic [spi_epsw_pkg::RUN_CNT_W-1:0]                  count_next;
    logic                                                take;

    assign result_valid = (count_reg != '0);
    assign result       = words_reg[0];
    assign take         = result_valid && !result_stall;
    // reload as the last word leaves
    assign can_load     = (count_reg == '0)
                          || ((count_reg == (spi_epsw_pkg::RUN_CNT_W)'(1)) && take);

    always_comb
    begin
        words_next = words_reg;
        count_next = count_reg;
        if (load)
        begin
            words_next = run.words;
            count_next = run.count;
        end
        else if (take)
        begin
            for (int i = 0; i < spi_epsw_pkg::MAX_RUN - 1; i++)
                words_next[i] = words_reg[i+1];
            count_next = count_reg - (spi_epsw_pkg::RUN_CNT_W)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

endmodule

// File: rtl/core/spi_eeprom_page_split_writer_unit.sv
// Channel  Direction  Word type    Handshake
// item     in         in_word_t    item_valid / item_stall
// result   out        out_word_t   result_valid / result_stall
// apb      in/out     32-bit regs  psel / penable / pwrite / pready
//
// An item is registered, then its whole result run (1 to 6 words) is formed
// combinationally and loaded into a shift buffer. The first word reaches the port
// from the input register through the buffer register; the buffer sends one word
// per cycle while result_stall is low, so the output shifter sets the item rate.
// Reset: opcodes 5/6/2, phase idle, address and count zero, both stages empty.
// result_stall holds the buffer; item_stall rises once the input stage is full
// and the buffer cannot reload.
module spi_eeprom_page_split_writer_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  spi_epsw_pkg::in_word_t               item,

    output logic                                 result_valid,
    input  logic                                 result_stall,
    output spi_epsw_pkg::out_word_t              result,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [spi_epsw_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [spi_epsw_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [spi_epsw_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    spi_epsw_pkg::cfg_t     cfg;
    spi_epsw_pkg::run_t     run;
    spi_epsw_pkg::in_word_t item_reg;
    logic                   item_valid_reg;
    logic                   item_valid_next;
    logic                   can_load;
    logic                   load;
    logic                   item_take;

    // input stage
    assign load       = item_valid_reg && can_load;
    assign item_stall = item_valid_reg && !can_load;
    assign item_take  = item_valid && !item_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (item_take)
            item_valid_next = 1'b1;
        else if (load)
            item_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            item_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= item_valid_next;
    end

    spi_epsw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // phase / address / count live here; state steps on load
    spi_epsw_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (load),
        .item  (item_reg),
        .cfg   (cfg),
        .run   (run)
    );

    spi_epsw_run_buf u_run_buf (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (load),
        .run          (run),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .can_load     (can_load)
    );

    // every run has at least one word
    a_load_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> result_valid)
        else $error("loaded run produced no word");

    // a run drains exactly at its last word unless another loads behind it
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && result.last_of_run && !load) |=> !result_valid)
        else $error("words left after last_of_run");

    // never load over a run still holding words besides its last
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && result_valid) |-> (result.last_of_run && !result_stall))
        else $error("run buffer overwritten");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> item_valid_reg)
        else $error("input stalled while stage empty");

endmodule
